// ===== sv/sdds_pkg.sv =====
`timescale 1ns / 1ps

package sdds_pkg;

    localparam logic [10:0] US_MIN   = 11'd1000;
    localparam logic [10:0] US_MAX   = 11'd2000;
    localparam logic [10:0] US_MID   = 11'd1500;
    localparam logic [6:0]  PCT_FULL = 7'd100;
    localparam logic [8:0]  RAMP_MAX = 9'd500;
    localparam logic [8:0]  RAMP_MIN = 9'd1;
    localparam logic [7:0]  STICK_OFS = 8'd100;
    // floor(m / 20) == (m * RECIP_20) >> 20 for every m below 2^16
    localparam logic [15:0] RECIP_20 = 16'd52429;
    localparam int          CFG_W    = 13;

    typedef enum logic [2:0] {
        CFG_THROTTLE_PCT   = 3'd0,
        CFG_STEERING_PCT   = 3'd1,
        CFG_REVERSE_MODE   = 3'd2,
        CFG_DRIFT_LOW_PCT  = 3'd3,
        CFG_DRIFT_HIGH_PCT = 3'd4,
        CFG_BOOST_PCT      = 3'd5,
        CFG_BOOST_MS       = 3'd6,
        CFG_RAMP_RATE      = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_OFF    = 3'b001,
        PH_ACTIVE = 3'b010,
        PH_BOOST  = 3'b100
    } t_phase;

    localparam logic [1:0] PHASE_CODE_OFF    = 2'd0;
    localparam logic [1:0] PHASE_CODE_ACTIVE = 2'd1;
    localparam logic [1:0] PHASE_CODE_BOOST  = 2'd2;

    typedef struct packed {
        logic [6:0]  throttle_pct;
        logic [6:0]  steering_pct;
        logic [1:0]  reverse_mode;
        logic [6:0]  drift_low_pct;
        logic [6:0]  drift_high_pct;
        logic [6:0]  boost_pct;
        logic [12:0] boost_ms;
        logic [8:0]  ramp_rate;
    } t_cfg;

    function automatic logic [6:0] sat_pct(input logic [6:0] p);
        return (p > PCT_FULL) ? PCT_FULL : p;
    endfunction

    // 500 * p / 100 is exactly 5 * p
    function automatic logic [8:0] pct_offset(input logic [6:0] p);
        return 9'({p, 2'b00}) + 9'(p);
    endfunction

endpackage

// ===== sv/sdds_steer.sv =====
`timescale 1ns / 1ps

module sdds_steer (
    input  logic [14:0]         i_mag_prod,
    input  logic                i_ofs_neg,
    input  logic                i_sx_zero,
    input  logic                i_left,
    input  logic                i_right,
    input  sdds_pkg::t_cfg      i_cfg,
    output logic [10:0]         o_steering_us
);

    logic [8:0]         range_us;
    logic [30:0]        recip_prod;
    logic [10:0]        quot;
    logic signed [12:0] sq;
    logic signed [12:0] raw;
    logic signed [12:0] mid;
    logic signed [12:0] rng;
    logic signed [12:0] us;
    logic               rev;

    always_comb begin
        range_us   = sdds_pkg::pct_offset(sdds_pkg::sat_pct(i_cfg.steering_pct));
        rev        = i_cfg.reverse_mode[1];
        // The stored product is |stick + 100| * percent; dividing by 20 gives the offset.
        recip_prod = 31'(i_mag_prod) * 31'(sdds_pkg::RECIP_20);
        quot       = recip_prod[30:20];
        sq         = i_ofs_neg ? -$signed(13'(quot)) : $signed(13'(quot));
        rng        = $signed(13'(range_us));
        mid        = $signed(13'(sdds_pkg::US_MID));
        raw        = sq - rng;
        us         = mid;
        if (!i_sx_zero) begin
            us = rev ? (mid - raw) : (mid + raw);
        end else if (i_left) begin
            us = rev ? (mid + rng) : (mid - rng);
        end else if (i_right) begin
            us = rev ? (mid - rng) : (mid + rng);
        end
        if (us < $signed(13'(sdds_pkg::US_MIN))) begin
            us = $signed(13'(sdds_pkg::US_MIN));
        end
        if (us > $signed(13'(sdds_pkg::US_MAX))) begin
            us = $signed(13'(sdds_pkg::US_MAX));
        end
        o_steering_us = us[10:0];
    end

endmodule

// ===== sv/servo_drive_drift_sequencer_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ----------------------------------------
// input     in         i_valid / o_stall    buttons, stick, d-pad, now_ms
// result    out        o_valid / i_stall    throttle_us, steering_us, drift_phase
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// Each word is held in the input register while the compute step runs, and its result is
// registered in the output register; one word is taken every cycle while no result is stalled.
// The stick product is formed on entry; the drift machine, throttle ramp and steering
// divide finish in the compute step, at one word per clock while no result is stalled.
// Reset is synchronous and restores the register defaults and the neutral throttle.
// A stalled result holds; the input register keeps taking words while the output is free.

module servo_drive_drift_sequencer_core #(
    parameter int DRIFT_HIGH_MS = 150,
    parameter int DRIFT_LOW_MS  = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_drift_button,
    input  logic                        i_accel_button,
    input  logic                        i_brake_button,
    input  logic signed [7:0]           i_stick_x,
    input  logic                        i_dpad_left,
    input  logic                        i_dpad_right,
    input  logic [31:0]                 i_now_ms,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [10:0]                 o_throttle_us,
    output logic [10:0]                 o_steering_us,
    output logic [1:0]                  o_drift_phase,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [sdds_pkg::CFG_W-1:0]  i_cfg_data
);

    sdds_pkg::t_cfg   r_cfg;
    sdds_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_pulse_start, n_pulse_start;
    logic             r_pulse_high, n_pulse_high;
    logic [31:0]      r_boost_start, n_boost_start;
    logic [10:0]      r_thr, n_thr;

    logic             r_in_valid;
    logic             r_out_valid;
    logic             r_drift, r_accel, r_brake, r_left, r_right;
    logic             r_sx_zero, r_ofs_neg;
    logic [14:0]      r_mag_prod;
    logic [31:0]      r_now;

    logic             accept, adv;
    logic [8:0]       stick_ofs;
    logic [7:0]       ofs_mag;
    logic [14:0]      mag_prod;

    logic             entering;
    logic [31:0]      eff_start, el_pulse, el_boost;
    logic             eff_high, flip;
    logic [6:0]       tgt_mag;
    logic             tgt_neg, up;
    logic [8:0]       tgt_ofs, rate;
    logic [10:0]      target;
    logic signed [11:0] diff;
    logic [10:0]      diff_mag;
    logic [1:0]       n_phase_code;
    logic [10:0]      steer_us;

    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;

    // Stick product is taken at entry so the divide-by-constant sits after a register.
    always_comb begin
        stick_ofs = {i_stick_x[7], i_stick_x} + 9'(sdds_pkg::STICK_OFS);
        ofs_mag   = stick_ofs[8] ? 8'(-stick_ofs) : stick_ofs[7:0];
        mag_prod  = 15'(ofs_mag) * 15'(sdds_pkg::sat_pct(r_cfg.steering_pct));
    end

    always_comb begin
        entering      = 1'b0;
        n_phase       = r_phase;
        n_boost_start = r_boost_start;
        el_boost      = r_now - r_boost_start;
        unique case (r_phase)
            sdds_pkg::PH_OFF: begin
                if (r_drift && r_accel) begin
                    n_phase  = sdds_pkg::PH_ACTIVE;
                    entering = 1'b1;
                end
            end
            sdds_pkg::PH_ACTIVE: begin
                if (!r_drift) begin
                    n_phase       = sdds_pkg::PH_BOOST;
                    n_boost_start = r_now;
                end
            end
            sdds_pkg::PH_BOOST: begin
                if (el_boost >= 32'(r_cfg.boost_ms)) begin
                    n_phase = sdds_pkg::PH_OFF;
                end
            end
            default: n_phase = r_phase;
        endcase

        eff_start = entering ? r_now : r_pulse_start;
        eff_high  = entering ? 1'b1 : r_pulse_high;
        el_pulse  = r_now - eff_start;
        flip      = eff_high ? (el_pulse >= 32'(DRIFT_HIGH_MS))
                             : (el_pulse >= 32'(DRIFT_LOW_MS));

        n_pulse_start = eff_start;
        n_pulse_high  = eff_high;
        tgt_neg       = 1'b0;
        tgt_mag       = '0;
        n_phase_code  = sdds_pkg::PHASE_CODE_OFF;
        unique case (n_phase)
            sdds_pkg::PH_BOOST: begin
                tgt_mag      = sdds_pkg::sat_pct(r_cfg.boost_pct);
                n_phase_code = sdds_pkg::PHASE_CODE_BOOST;
            end
            sdds_pkg::PH_ACTIVE: begin
                tgt_mag      = eff_high ? sdds_pkg::sat_pct(r_cfg.drift_high_pct)
                                        : sdds_pkg::sat_pct(r_cfg.drift_low_pct);
                n_phase_code = sdds_pkg::PHASE_CODE_ACTIVE;
                if (flip) begin
                    n_pulse_high  = !eff_high;
                    n_pulse_start = r_now;
                end
            end
            default: begin
                if (r_accel) begin
                    tgt_mag = sdds_pkg::sat_pct(r_cfg.throttle_pct);
                end else if (r_brake) begin
                    tgt_mag = sdds_pkg::sat_pct(r_cfg.throttle_pct);
                    tgt_neg = 1'b1;
                end
            end
        endcase

        tgt_ofs = sdds_pkg::pct_offset(tgt_mag);
        up      = !tgt_neg ^ r_cfg.reverse_mode[0];
        target  = up ? (sdds_pkg::US_MID + 11'(tgt_ofs)) : (sdds_pkg::US_MID - 11'(tgt_ofs));

        if (r_cfg.ramp_rate < sdds_pkg::RAMP_MIN) begin
            rate = sdds_pkg::RAMP_MIN;
        end else if (r_cfg.ramp_rate > sdds_pkg::RAMP_MAX) begin
            rate = sdds_pkg::RAMP_MAX;
        end else begin
            rate = r_cfg.ramp_rate;
        end
        diff     = $signed({1'b0, target}) - $signed({1'b0, r_thr});
        diff_mag = diff[11] ? 11'(-diff) : diff[10:0];
        if (diff_mag <= 11'(rate)) begin
            n_thr = target;
        end else if (diff[11]) begin
            n_thr = r_thr - 11'(rate);
        end else begin
            n_thr = r_thr + 11'(rate);
        end
    end

    sdds_steer u_steer (
        .i_mag_prod    (r_mag_prod),
        .i_ofs_neg     (r_ofs_neg),
        .i_sx_zero     (r_sx_zero),
        .i_left        (r_left),
        .i_right       (r_right),
        .i_cfg         (r_cfg),
        .o_steering_us (steer_us)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.throttle_pct   <= 7'd75;
            r_cfg.steering_pct   <= 7'd100;
            r_cfg.reverse_mode   <= 2'd3;
            r_cfg.drift_low_pct  <= 7'd50;
            r_cfg.drift_high_pct <= 7'd95;
            r_cfg.boost_pct      <= 7'd100;
            r_cfg.boost_ms       <= 13'd500;
            r_cfg.ramp_rate      <= 9'd5;
        end else if (i_cfg_we) begin
            unique case (sdds_pkg::t_cfg_idx'(i_cfg_idx))
                sdds_pkg::CFG_THROTTLE_PCT:   r_cfg.throttle_pct   <= i_cfg_data[6:0];
                sdds_pkg::CFG_STEERING_PCT:   r_cfg.steering_pct   <= i_cfg_data[6:0];
                sdds_pkg::CFG_REVERSE_MODE:   r_cfg.reverse_mode   <= i_cfg_data[1:0];
                sdds_pkg::CFG_DRIFT_LOW_PCT:  r_cfg.drift_low_pct  <= i_cfg_data[6:0];
                sdds_pkg::CFG_DRIFT_HIGH_PCT: r_cfg.drift_high_pct <= i_cfg_data[6:0];
                sdds_pkg::CFG_BOOST_PCT:      r_cfg.boost_pct      <= i_cfg_data[6:0];
                sdds_pkg::CFG_BOOST_MS:       r_cfg.boost_ms       <= i_cfg_data[12:0];
                sdds_pkg::CFG_RAMP_RATE:      r_cfg.ramp_rate      <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= sdds_pkg::PH_OFF;
            r_pulse_start <= '0;
            r_pulse_high  <= 1'b0;
            r_boost_start <= '0;
            r_thr         <= sdds_pkg::US_MID;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid   <= 1'b1;
                r_phase       <= n_phase;
                r_pulse_start <= n_pulse_start;
                r_pulse_high  <= n_pulse_high;
                r_boost_start <= n_boost_start;
                r_thr         <= n_thr;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drift    <= i_drift_button;
            r_accel    <= i_accel_button;
            r_brake    <= i_brake_button;
            r_left     <= i_dpad_left;
            r_right    <= i_dpad_right;
            r_sx_zero  <= (i_stick_x == 8'sd0);
            r_ofs_neg  <= stick_ofs[8];
            r_mag_prod <= mag_prod;
            r_now      <= i_now_ms;
        end
        if (adv) begin
            o_throttle_us <= n_thr;
            o_steering_us <= steer_us;
            o_drift_phase <= n_phase_code;
        end
    end

endmodule

// ===== sim/servo_drive_drift_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module servo_drive_drift_sequencer_core_tb;

    localparam int DRIFT_HIGH_MS = 150;
    localparam int DRIFT_LOW_MS  = 100;
    localparam int PULSE_MIN     = int'(sdds_pkg::US_MIN);
    localparam int PULSE_MAX     = int'(sdds_pkg::US_MAX);
    localparam int PULSE_MID     = int'(sdds_pkg::US_MID);
    localparam int PCT_LIMIT     = int'(sdds_pkg::PCT_FULL);
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 3000;

    typedef struct {
        logic        drift;
        logic        accel;
        logic        brake;
        logic [7:0]  stick;
        logic        left;
        logic        right;
        logic [31:0] now;
    } t_drive_tick;

    typedef struct {
        logic [10:0] throttle_us;
        logic [10:0] steering_us;
        logic [1:0]  phase;
    } t_servo_cmd;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              tx_valid = 1'b0;
    logic              rx_stall = 1'b0;
    logic              drift_btn = 1'b0;
    logic              accel_btn = 1'b0;
    logic              brake_btn = 1'b0;
    logic [7:0]        stick_x = '0;
    logic              dpad_l = 1'b0;
    logic              dpad_r = 1'b0;
    logic [31:0]       now_ms = '0;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_idx = '0;
    logic [sdds_pkg::CFG_W-1:0] cfg_data = '0;
    logic              o_stall;
    logic              o_valid;
    logic [10:0]       o_throttle_us;
    logic [10:0]       o_steering_us;
    logic [1:0]        o_drift_phase;

    servo_drive_drift_sequencer_core #(
        .DRIFT_HIGH_MS (DRIFT_HIGH_MS),
        .DRIFT_LOW_MS  (DRIFT_LOW_MS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (tx_valid),
        .o_stall        (o_stall),
        .i_drift_button (drift_btn),
        .i_accel_button (accel_btn),
        .i_brake_button (brake_btn),
        .i_stick_x      (stick_x),
        .i_dpad_left    (dpad_l),
        .i_dpad_right   (dpad_r),
        .i_now_ms       (now_ms),
        .o_valid        (o_valid),
        .i_stall        (rx_stall),
        .o_throttle_us  (o_throttle_us),
        .o_steering_us  (o_steering_us),
        .o_drift_phase  (o_drift_phase),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Register copy and drift state of the predictor.
    logic [6:0]  cfg_throttle;
    logic [6:0]  cfg_steering;
    logic [1:0]  cfg_reverse;
    logic [6:0]  cfg_drift_low;
    logic [6:0]  cfg_drift_high;
    logic [6:0]  cfg_boost;
    logic [12:0] cfg_boost_ms;
    logic [8:0]  cfg_ramp;
    logic [1:0]  drive_phase;
    logic [31:0] pulse_t0;
    logic        pulse_high;
    logic [31:0] boost_t0;
    int          throttle_now;

    t_servo_cmd  servo_cmds_due[$];
    t_servo_cmd  due_cmd;
    int          mismatches = 0;
    int          ticks_sent = 0;
    int          words_checked = 0;
    int          settings_used = 1;
    int          drift_entries = 0;
    int          boost_exits = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;

    // Scenario state for the random ticks.
    logic [31:0] clock_ms = 32'd0;
    int          seg_kind = 0;
    int          seg_left = 0;
    bit          seg_first = 1'b0;

    task automatic reset_drive_model();
        cfg_throttle   = 7'd75;
        cfg_steering   = 7'd100;
        cfg_reverse    = 2'd3;
        cfg_drift_low  = 7'd50;
        cfg_drift_high = 7'd95;
        cfg_boost      = 7'd100;
        cfg_boost_ms   = 13'd500;
        cfg_ramp       = 9'd5;
        drive_phase    = sdds_pkg::PHASE_CODE_OFF;
        pulse_t0       = '0;
        pulse_high     = 1'b0;
        boost_t0       = '0;
        throttle_now   = PULSE_MID;
    endtask

    function automatic int pct_limit(logic [6:0] p);
        return (int'(p) > PCT_LIMIT) ? PCT_LIMIT : int'(p);
    endfunction

    // Signed percent to pulse width; bit 0 of the reverse register flips the sense.
    function automatic int pct_to_pulse(int pct);
        int mag;
        int ofs;
        mag = (pct < 0) ? -pct : pct;
        ofs = (PULSE_MID - PULSE_MIN) * mag / PCT_LIMIT;
        if (pct == 0) return PULSE_MID;
        if ((pct > 0) != cfg_reverse[0]) return PULSE_MID + ofs;
        return PULSE_MID - ofs;
    endfunction

    task automatic advance_drive(input t_drive_tick t, output t_servo_cmd c);
        logic [31:0] elapsed;
        int          target;
        int          rate;
        int          diff;
        int          sx;
        int          range;
        int          raw;
        int          steer;
        target = PULSE_MID;
        case (drive_phase)
            sdds_pkg::PHASE_CODE_OFF: begin
                if (t.drift && t.accel) begin
                    drive_phase = sdds_pkg::PHASE_CODE_ACTIVE;
                    pulse_high  = 1'b1;
                    pulse_t0    = t.now;
                    drift_entries++;
                end
            end
            sdds_pkg::PHASE_CODE_ACTIVE: begin
                if (!t.drift) begin
                    drive_phase = sdds_pkg::PHASE_CODE_BOOST;
                    boost_t0    = t.now;
                end
            end
            sdds_pkg::PHASE_CODE_BOOST: begin
                elapsed = t.now - boost_t0;
                if (elapsed >= 32'(cfg_boost_ms)) begin
                    drive_phase = sdds_pkg::PHASE_CODE_OFF;
                    boost_exits++;
                end
            end
            default: ;
        endcase

        if (drive_phase == sdds_pkg::PHASE_CODE_BOOST) begin
            target = pct_to_pulse(pct_limit(cfg_boost));
        end else if (drive_phase == sdds_pkg::PHASE_CODE_ACTIVE) begin
            // The pulse flips after its target is taken, so the change shows next tick.
            elapsed = t.now - pulse_t0;
            if (pulse_high) begin
                target = pct_to_pulse(pct_limit(cfg_drift_high));
                if (elapsed >= 32'(DRIFT_HIGH_MS)) begin
                    pulse_high = 1'b0;
                    pulse_t0   = t.now;
                end
            end else begin
                target = pct_to_pulse(pct_limit(cfg_drift_low));
                if (elapsed >= 32'(DRIFT_LOW_MS)) begin
                    pulse_high = 1'b1;
                    pulse_t0   = t.now;
                end
            end
        end else if (t.accel) begin
            target = pct_to_pulse(pct_limit(cfg_throttle));
        end else if (t.brake) begin
            target = pct_to_pulse(-pct_limit(cfg_throttle));
        end

        rate = int'(cfg_ramp);
        if (rate < 1) rate = 1;
        if (rate > 500) rate = 500;
        diff = target - throttle_now;
        if (((diff < 0) ? -diff : diff) <= rate) throttle_now = target;
        else if (diff > 0) throttle_now += rate;
        else throttle_now -= rate;

        sx    = int'($signed(t.stick));
        range = (PULSE_MID - PULSE_MIN) * pct_limit(cfg_steering) / PCT_LIMIT;
        steer = PULSE_MID;
        if (sx != 0) begin
            // Integer division truncates toward zero, as it must for sticks below -100.
            raw   = (sx + 100) * (2 * range) / 200 - range;
            steer = PULSE_MID + (cfg_reverse[1] ? -raw : raw);
        end else if (t.left) begin
            steer = cfg_reverse[1] ? PULSE_MID + range : PULSE_MID - range;
        end else if (t.right) begin
            steer = cfg_reverse[1] ? PULSE_MID - range : PULSE_MID + range;
        end
        if (steer < PULSE_MIN) steer = PULSE_MIN;
        if (steer > PULSE_MAX) steer = PULSE_MAX;

        c.throttle_us = 11'(throttle_now);
        c.steering_us = 11'(steer);
        c.phase       = drive_phase;
    endtask

    // Called just after a falling edge; returns at the falling edge after acceptance.
    task automatic send_tick(input t_drive_tick t);
        t_servo_cmd cmd;
        while (!quiet && $urandom_range(99) < 22) begin
            tx_valid <= 1'b0;
            @(negedge i_clk);
        end
        tx_valid  <= 1'b1;
        drift_btn <= t.drift;
        accel_btn <= t.accel;
        brake_btn <= t.brake;
        stick_x   <= t.stick;
        dpad_l    <= t.left;
        dpad_r    <= t.right;
        now_ms    <= t.now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        advance_drive(t, cmd);
        servo_cmds_due.push_back(cmd);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic press_pad(input logic d, input logic a, input logic b, input int sx,
                             input logic l, input logic r, input logic [31:0] now);
        t_drive_tick t;
        t.drift = d;
        t.accel = a;
        t.brake = b;
        t.stick = 8'(sx);
        t.left  = l;
        t.right = r;
        t.now   = now;
        send_tick(t);
    endtask

    // Drops valid and waits until every expected word has come back.
    task automatic settle();
        tx_valid <= 1'b0;
        wait (servo_cmds_due.size() == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input sdds_pkg::t_cfg_idx idx, input int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= sdds_pkg::CFG_W'(value);
        @(posedge i_clk);
        case (idx)
            sdds_pkg::CFG_THROTTLE_PCT:   cfg_throttle   = 7'(value);
            sdds_pkg::CFG_STEERING_PCT:   cfg_steering   = 7'(value);
            sdds_pkg::CFG_REVERSE_MODE:   cfg_reverse    = 2'(value);
            sdds_pkg::CFG_DRIFT_LOW_PCT:  cfg_drift_low  = 7'(value);
            sdds_pkg::CFG_DRIFT_HIGH_PCT: cfg_drift_high = 7'(value);
            sdds_pkg::CFG_BOOST_PCT:      cfg_boost      = 7'(value);
            sdds_pkg::CFG_BOOST_MS:       cfg_boost_ms   = 13'(value);
            sdds_pkg::CFG_RAMP_RATE:      cfg_ramp       = 9'(value);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic program_regs(input int unsigned thr, input int unsigned str,
                                input int unsigned rev, input int unsigned lo,
                                input int unsigned hi, input int unsigned bst,
                                input int unsigned bms, input int unsigned ramp);
        settle();
        write_reg(sdds_pkg::CFG_THROTTLE_PCT, thr);
        write_reg(sdds_pkg::CFG_STEERING_PCT, str);
        write_reg(sdds_pkg::CFG_REVERSE_MODE, rev);
        write_reg(sdds_pkg::CFG_DRIFT_LOW_PCT, lo);
        write_reg(sdds_pkg::CFG_DRIFT_HIGH_PCT, hi);
        write_reg(sdds_pkg::CFG_BOOST_PCT, bst);
        write_reg(sdds_pkg::CFG_BOOST_MS, bms);
        write_reg(sdds_pkg::CFG_RAMP_RATE, ramp);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic int unsigned rand_pct();
        return ($urandom_range(9) == 0) ? $urandom_range(127, 101) : $urandom_range(100);
    endfunction

    // Mostly drift sequences (press, hold, release, wait out the boost) with random
    // buttons, stick and time steps between noise segments; a tenth get a random drift bit.
    task automatic drive_laps(input int count);
        t_drive_tick t;
        int          r;
        repeat (count) begin
            if (seg_left == 0) begin
                if (seg_kind == 1) begin
                    seg_kind = 2;
                    seg_left = $urandom_range(1, 15);
                end else if ($urandom_range(99) < 50) begin
                    seg_kind  = 1;
                    seg_left  = $urandom_range(2, 20);
                    seg_first = 1'b1;
                end else begin
                    seg_kind = 0;
                    seg_left = $urandom_range(1, 12);
                end
            end
            seg_left--;

            t.accel = 1'($urandom_range(1));
            t.brake = 1'($urandom_range(1));
            case (seg_kind)
                1: begin
                    t.drift = 1'b1;
                    if (seg_first) t.accel = 1'b1;
                    seg_first = 1'b0;
                end
                2: t.drift = 1'b0;
                default: t.drift = ($urandom_range(9) == 0);
            endcase
            if ($urandom_range(9) == 0) t.drift = 1'($urandom_range(1));

            r = $urandom_range(99);
            if (r < 5) ;
            else if (r < 80) clock_ms += $urandom_range(1, 40);
            else if (r < 95) clock_ms += $urandom_range(41, 300);
            else if (r < 99) clock_ms += $urandom_range(300, 6000);
            else clock_ms = $urandom;
            t.now = clock_ms;

            r = $urandom_range(99);
            if (r < 15) t.stick = 8'd0;
            else if (r < 85) t.stick = 8'($urandom_range(200) - 100);
            else t.stick = 8'($urandom_range(255));
            t.left  = 1'($urandom_range(1));
            t.right = 1'($urandom_range(1));
            send_tick(t);
        end
    endtask

    task automatic test_directed_defaults();
        logic [31:0] base;
        base = 32'hFFFF_FFC0;
        press_pad(0, 0, 0, 0, 0, 0, 32'h0000_0000);
        press_pad(0, 1, 0, 100, 0, 0, 32'hFFFF_FFFF);
        press_pad(0, 0, 1, -100, 0, 0, 32'd5);
        press_pad(0, 1, 1, -128, 0, 0, 32'd6);
        press_pad(0, 0, 0, 127, 0, 0, 32'd7);
        press_pad(0, 0, 0, 0, 1, 0, 32'd8);
        press_pad(0, 0, 0, 0, 0, 1, 32'd9);
        // Both d-pad bits with a centred stick: left wins.
        press_pad(0, 0, 0, 0, 1, 1, 32'd10);
        // Drift alone does not start the sequence.
        press_pad(1, 0, 0, -1, 1, 1, 32'd11);
        // Full drift cycle straddling the wrap of the millisecond counter.
        press_pad(1, 1, 0, 20, 0, 0, base);
        press_pad(1, 0, 1, 0, 0, 0, base + 149);
        press_pad(1, 0, 0, 0, 1, 0, base + 150);
        press_pad(1, 1, 0, -50, 0, 0, base + 249);
        press_pad(1, 0, 0, 50, 0, 0, base + 250);
        press_pad(1, 0, 0, 0, 0, 1, base + 400);
        press_pad(0, 1, 0, 3, 0, 0, base + 410);
        press_pad(0, 0, 0, -3, 0, 0, base + 909);
        press_pad(0, 1, 0, 0, 0, 0, base + 910);
        press_pad(1, 1, 0, 99, 0, 0, base + 911);
        press_pad(0, 0, 0, -99, 0, 0, base + 911);
        press_pad(0, 0, 1, 1, 0, 0, base + 5000);
        clock_ms = base + 5000;
    endtask

    task automatic test_register_extremes();
        // All zero: no ramp rate is taken as one, and a zero boost ends at once.
        program_regs(0, 0, 0, 0, 0, 0, 0, 0);
        drive_laps(50);
        // Every bit set: percentages saturate at full scale, ramp at 500.
        program_regs(127, 127, 3, 127, 127, 127, 8191, 511);
        drive_laps(50);
        program_regs(100, 100, 1, 100, 0, 100, 5000, 500);
        drive_laps(50);
        program_regs(1, 100, 2, 0, 100, 1, 1, 1);
        drive_laps(50);
    endtask

    task automatic test_random_settings();
        repeat (6) begin
            program_regs(rand_pct(), rand_pct(), $urandom_range(3), rand_pct(), rand_pct(),
                         rand_pct(),
                         ($urandom_range(5) == 0) ? $urandom_range(8191) : $urandom_range(400),
                         ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(1, 60));
            drive_laps(100);
        end
    endtask

    // The result side holds off for a long stretch while ticks keep coming.
    task automatic test_output_hold_off();
        settle();
        @(posedge i_clk);
        hold_request = 1'b1;
        @(negedge i_clk);
        drive_laps(40);
    endtask

    task automatic test_back_to_back();
        settle();
        quiet = 1'b1;
        drive_laps(120);
        settle();
        quiet = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rx_stall <= 1'b1;
        end else begin
            rx_stall <= !quiet && ($urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !rx_stall) begin
            if (servo_cmds_due.size() == 0) begin
                $display("%0t: servo word with none expected: throttle %0d steering %0d phase %0d",
                         $time, o_throttle_us, o_steering_us, o_drift_phase);
                mismatches++;
            end else begin
                due_cmd = servo_cmds_due.pop_front();
                words_checked++;
                if (o_throttle_us !== due_cmd.throttle_us) begin
                    $display("%0t: throttle_us expected %0d, actual %0d",
                             $time, due_cmd.throttle_us, o_throttle_us);
                    mismatches++;
                end
                if (o_steering_us !== due_cmd.steering_us) begin
                    $display("%0t: steering_us expected %0d, actual %0d",
                             $time, due_cmd.steering_us, o_steering_us);
                    mismatches++;
                end
                if (o_drift_phase !== due_cmd.phase) begin
                    $display("%0t: drift_phase expected %0d, actual %0d",
                             $time, due_cmd.phase, o_drift_phase);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((tx_valid && !o_stall) || (o_valid && !rx_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        reset_drive_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_defaults();
        test_register_extremes();
        test_random_settings();
        test_output_hold_off();
        test_back_to_back();

        settle();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d ticks under %0d register settings, checked %0d servo words.",
                 ticks_sent, settings_used, words_checked);
        $display("Drift sequences entered %0d times, boost ran out %0d times.",
                 drift_entries, boost_exits);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
